// File: hdl/infix_to_postfix_converter_top_macros.svh
// Assertion macros used by the checker file.
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define ITP_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define ITP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: hdl/itp_pkg.sv
package itp_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int SYM_W = 8;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 16;
	localparam int OUT_TUSER_W = 3;

	localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
	localparam logic [SYM_W-1:0] CH_OPEN = 8'h28;
	localparam logic [SYM_W-1:0] CH_CLOSE = 8'h29;
	localparam logic [SYM_W-1:0] CH_MUL = 8'h2A;
	localparam logic [SYM_W-1:0] CH_PLUS = 8'h2B;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] CH_DIV = 8'h2F;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_OPEN = 3'd1,
		OP_PLUS = 3'd2,
		OP_MINUS = 3'd3,
		OP_MUL = 3'd4,
		OP_DIV = 3'd5
	} op_code_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_UNMATCHED = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	function automatic op_code_t code_of(input logic [SYM_W-1:0] sym);
		op_code_t c;
		unique case (sym)
			CH_OPEN: c = OP_OPEN;
			CH_PLUS: c = OP_PLUS;
			CH_MINUS: c = OP_MINUS;
			CH_MUL: c = OP_MUL;
			CH_DIV: c = OP_DIV;
			default: c = OP_NONE;
		endcase
		return c;
	endfunction

	function automatic logic [SYM_W-1:0] char_of(input op_code_t c);
		logic [SYM_W-1:0] ch;
		unique case (c)
			OP_OPEN: ch = CH_OPEN;
			OP_PLUS: ch = CH_PLUS;
			OP_MINUS: ch = CH_MINUS;
			OP_MUL: ch = CH_MUL;
			OP_DIV: ch = CH_DIV;
			default: ch = '0;
		endcase
		return ch;
	endfunction

	function automatic logic [1:0] prio_of(input op_code_t c);
		logic [1:0] p;
		unique case (c)
			OP_MUL, OP_DIV: p = 2'd3;
			OP_PLUS, OP_MINUS: p = 2'd2;
			OP_OPEN: p = 2'd1;
			default: p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

// File: hdl/infix_to_postfix_converter_top.sv
// An input transaction runs through accept, dispatch (which emits the space or the passed-through
// character), the steps that emit further results, steps that emit nothing (pop loop exit, push,
// discard of the open parenthesis) and a close-out. A result waits in a hold register until the next
// result or the close-out moves it to the output register; the last one becomes valid as s_tready
// rises again. A stalled result stalls the sequencer.
// arst_n clears the sequencer, the stack count and both result valids; stack entries are not reset.
module infix_to_postfix_converter_top #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [itp_pkg::IN_TDATA_W-1:0] s_tdata, // symbol
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	output logic [itp_pkg::OUT_TDATA_W-1:0] m_tdata, // out_symbol, last_of_item
	output logic [itp_pkg::OUT_TUSER_W-1:0] m_tuser, // has_symbol, status
	output logic m_tlast
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(STACK_DEPTH);
	localparam int PAD_W = itp_pkg::OUT_TDATA_W - itp_pkg::SYM_W - 1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_FIRST = 6'b000010,
		S_POP = 6'b000100,
		S_PUSH = 6'b001000,
		S_CLOSE = 6'b010000,
		S_END = 6'b100000
	} state_t;

	typedef struct packed {
		logic [itp_pkg::SYM_W-1:0] sym;
		logic has;
		itp_pkg::status_t status;
	} res_t;

	state_t state_q, state_d;
	logic [itp_pkg::SYM_W-1:0] sym_q;
	logic fin_q;
	logic close_q;
	itp_pkg::op_code_t code_q;
	logic [CNT_W-1:0] cnt_q;
	itp_pkg::op_code_t stack_q [STACK_DEPTH];
	res_t hold_q, out_q;
	logic hold_v_q, out_valid_q, out_last_q, out_end_q;

	logic [CNT_W-1:0] cnt_m1;
	itp_pkg::op_code_t top_code;
	logic full, out_free, can_emit;
	logic do_emit, cnt_dec, do_push, do_final;
	res_t new_res;

	assign cnt_m1 = cnt_q - CNT_W'(1);
	assign top_code = (cnt_q != '0) ? stack_q[cnt_m1[IDX_W-1:0]] : itp_pkg::OP_NONE;
	assign full = (cnt_q == CNT_W'(STACK_DEPTH));
	assign out_free = !out_valid_q || m_tready;
	assign can_emit = !hold_v_q || out_free;

	always_comb begin
		state_d = state_q;
		do_emit = 1'b0;
		cnt_dec = 1'b0;
		do_push = 1'b0;
		do_final = 1'b0;
		new_res = '{sym: itp_pkg::char_of(top_code), has: 1'b1, status: itp_pkg::ST_OK};
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_FIRST;
				end
			end
			S_FIRST: begin
				if (close_q) begin
					state_d = S_CLOSE;
				end else if (code_q == itp_pkg::OP_OPEN) begin
					state_d = S_PUSH;
				end else if (code_q != itp_pkg::OP_NONE) begin
					new_res.sym = itp_pkg::CH_SPACE;
					if (can_emit) begin
						do_emit = 1'b1;
						state_d = S_POP;
					end
				end else begin
					new_res.sym = sym_q;
					if (can_emit) begin
						do_emit = 1'b1;
						state_d = S_END;
					end
				end
			end
			S_POP: begin
				if (cnt_q != '0 && itp_pkg::prio_of(top_code) >= itp_pkg::prio_of(code_q)) begin
					if (can_emit) begin
						do_emit = 1'b1;
						cnt_dec = 1'b1;
					end
				end else begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				if (full) begin
					new_res = '{sym: '0, has: 1'b0, status: itp_pkg::ST_OVERFLOW};
					if (can_emit) begin
						do_emit = 1'b1;
						state_d = S_END;
					end
				end else begin
					do_push = 1'b1;
					state_d = S_END;
				end
			end
			S_CLOSE: begin
				if (cnt_q != '0 && top_code != itp_pkg::OP_OPEN) begin
					if (can_emit) begin
						do_emit = 1'b1;
						cnt_dec = 1'b1;
					end
				end else if (cnt_q != '0) begin
					cnt_dec = 1'b1;
					state_d = S_END;
				end else begin
					new_res = '{sym: '0, has: 1'b0, status: itp_pkg::ST_UNMATCHED};
					if (can_emit) begin
						do_emit = 1'b1;
						state_d = S_END;
					end
				end
			end
			S_END: begin
				if (fin_q && cnt_q != '0) begin
					if (can_emit) begin
						do_emit = 1'b1;
						cnt_dec = 1'b1;
					end
				end else if (hold_v_q || fin_q) begin
					if (out_free) begin
						do_final = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			hold_v_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_dec) begin
				cnt_q <= cnt_m1;
			end else if (do_push) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (do_emit) begin
				hold_v_q <= 1'b1;
			end else if (do_final) begin
				hold_v_q <= 1'b0;
			end
			if (do_final || (do_emit && hold_v_q)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sym_q <= s_tdata[itp_pkg::SYM_W-1:0];
			fin_q <= s_tlast;
			close_q <= (s_tdata[itp_pkg::SYM_W-1:0] == itp_pkg::CH_CLOSE);
			code_q <= itp_pkg::code_of(s_tdata[itp_pkg::SYM_W-1:0]);
		end
		if (do_push) begin
			stack_q[cnt_q[IDX_W-1:0]] <= code_q;
		end
		if (do_emit) begin
			hold_q <= new_res;
		end
		if (do_final) begin
			out_q <= hold_v_q ? hold_q : res_t'{sym: '0, has: 1'b0, status: itp_pkg::ST_OK};
			out_last_q <= 1'b1;
			out_end_q <= fin_q;
		end else if (do_emit && hold_v_q) begin
			out_q <= hold_q;
			out_last_q <= 1'b0;
			out_end_q <= 1'b0;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = {PAD_W'(0), out_last_q, out_q.sym};
	assign m_tuser = {out_q.status, out_q.has};
	assign m_tlast = out_end_q;

endmodule

// File: hdl/itp_checker.sv
`include "infix_to_postfix_converter_top_macros.svh"

module itp_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [itp_pkg::IN_TDATA_W-1:0] s_tdata,
	input logic s_tlast,
	input logic m_tvalid,
	input logic m_tready,
	input logic [itp_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [itp_pkg::OUT_TUSER_W-1:0] m_tuser,
	input logic m_tlast
);

	logic stall, res_v, has_sym;
	logic [7:0] out_sym;
	logic [1:0] st;
	logic [itp_pkg::OUT_TDATA_W+itp_pkg::OUT_TUSER_W:0] m_all;

	assign stall = m_tvalid && !m_tready;
	assign res_v = m_tvalid;
	assign has_sym = m_tuser[0];
	assign out_sym = m_tdata[7:0];
	assign st = m_tuser[2:1];
	assign m_all = {m_tdata, m_tuser, m_tlast};

	// A stalled result transaction keeps its valid and its payload.
	`ITP_ASSERT_NEXT(a_out_hold, stall, m_tvalid && $stable(m_all), "stalled result changed")

	// The end of an expression is always the last result of its character.
	`ITP_ASSERT_IMPL(a_end_is_last, res_v && m_tlast, m_tdata[8], "end without last_of_item")

	// Status and end-marker results carry no character.
	`ITP_ASSERT_IMPL(a_no_sym_zero, res_v && !has_sym, out_sym == '0, "symbol without has_symbol")

	// Character results report an ok status.
	`ITP_ASSERT_IMPL(a_status_ok, res_v && has_sym, st == itp_pkg::ST_OK, "character with status")

	// The padding bits of a result are zero.
	`ITP_ASSERT_IMPL(a_no_accept_pad, res_v, m_tdata[15:9] == '0, "padding bits not zero")

endmodule

bind infix_to_postfix_converter_top itp_checker u_itp_checker (.*);

// File: sim/tb_infix_to_postfix_converter_top.sv
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter_top;

	localparam int DEPTH = itp_pkg::STACK_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 120;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 60;

	typedef struct {
		logic [7:0] sym;
		logic has_sym;
		itp_pkg::status_t status;
		logic last_of_item;
		logic expr_end;
	} postfix_res_t;

	typedef struct {
		logic [7:0] sym;
		logic fin;
		int reps;
		logic typed;
		postfix_res_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [itp_pkg::IN_TDATA_W-1:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [itp_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic [itp_pkg::OUT_TUSER_W-1:0] m_tuser;
	logic m_tlast;

	postfix_res_t expected_postfix_q[$];
	postfix_res_t char_results_q[$];
	postfix_res_t got_want;
	itp_pkg::op_code_t op_stack[DEPTH];
	int op_depth;
	int mismatch_count;
	int sent_count;
	int cycle_count;
	logic burst;
	logic hold_rx;
	logic [7:0] held_sym;
	logic have_held;

	postfix_res_t blank_res = '{8'h00, 1'b0, itp_pkg::ST_OK, 1'b0, 1'b0};

	stim_row_t directed_rows[21] = '{
		'{8'h00, 1'b0, 1, 1'b1, '{8'h00, 1'b1, itp_pkg::ST_OK, 1'b1, 1'b0}},
		'{8'hFF, 1'b0, 1, 1'b1, '{8'hFF, 1'b1, itp_pkg::ST_OK, 1'b1, 1'b0}},
		'{itp_pkg::CH_CLOSE, 1'b0, 1, 1'b1, '{8'h00, 1'b0, itp_pkg::ST_UNMATCHED, 1'b1, 1'b0}},
		'{itp_pkg::CH_OPEN, 1'b0, 1, 1'b0, '{8'h00, 1'b0, itp_pkg::ST_OK, 1'b0, 1'b0}},
		'{itp_pkg::CH_CLOSE, 1'b1, 1, 1'b1, '{8'h00, 1'b0, itp_pkg::ST_OK, 1'b1, 1'b1}},
		'{"7", 1'b1, 1, 1'b1, '{"7", 1'b1, itp_pkg::ST_OK, 1'b1, 1'b1}},
		'{itp_pkg::CH_OPEN, 1'b0, DEPTH, 1'b0, '{8'h00, 1'b0, itp_pkg::ST_OK, 1'b0, 1'b0}},
		'{itp_pkg::CH_OPEN, 1'b0, 1, 1'b1, '{8'h00, 1'b0, itp_pkg::ST_OVERFLOW, 1'b1, 1'b0}},
		'{"x", 1'b1, 1, 1'b0, '{8'h00, 1'b0, itp_pkg::ST_OK, 1'b0, 1'b0}},
		'{"a", 1'b0, 1, 1'b0, '{8'h00, 1'b0, itp_pkg::ST_OK, 1'b0, 1'b0}},
		'{itp_pkg::CH_MUL, 1'b0, 1, 1'b0, '{8'h00, 1'b0, itp_pkg::ST_OK, 1'b0, 1'b0}},
		'{"b", 1'b0, 1, 1'b0, '{8'h00, 1'b0, itp_pkg::ST_OK, 1'b0, 1'b0}},
		'{itp_pkg::CH_MINUS, 1'b0, 1, 1'b0, '{8'h00, 1'b0, itp_pkg::ST_OK, 1'b0, 1'b0}},
		'{itp_pkg::CH_OPEN, 1'b0, 1, 1'b0, '{8'h00, 1'b0, itp_pkg::ST_OK, 1'b0, 1'b0}},
		'{"c", 1'b0, 1, 1'b0, '{8'h00, 1'b0, itp_pkg::ST_OK, 1'b0, 1'b0}},
		'{itp_pkg::CH_DIV, 1'b0, 1, 1'b0, '{8'h00, 1'b0, itp_pkg::ST_OK, 1'b0, 1'b0}},
		'{"d", 1'b0, 1, 1'b0, '{8'h00, 1'b0, itp_pkg::ST_OK, 1'b0, 1'b0}},
		'{itp_pkg::CH_CLOSE, 1'b0, 1, 1'b0, '{8'h00, 1'b0, itp_pkg::ST_OK, 1'b0, 1'b0}},
		'{itp_pkg::CH_PLUS, 1'b0, 1, 1'b0, '{8'h00, 1'b0, itp_pkg::ST_OK, 1'b0, 1'b0}},
		'{"e", 1'b0, 1, 1'b0, '{8'h00, 1'b0, itp_pkg::ST_OK, 1'b0, 1'b0}},
		'{itp_pkg::CH_CLOSE, 1'b1, 1, 1'b0, '{8'h00, 1'b0, itp_pkg::ST_OK, 1'b0, 1'b0}}
	};

	infix_to_postfix_converter_top #(
		.STACK_DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #6 clk = ~clk;

	function automatic int op_rank(input itp_pkg::op_code_t c);
		unique case (c)
			itp_pkg::OP_MUL, itp_pkg::OP_DIV: return 3;
			itp_pkg::OP_PLUS, itp_pkg::OP_MINUS: return 2;
			itp_pkg::OP_OPEN: return 1;
			default: return 0;
		endcase
	endfunction

	function automatic logic [7:0] op_symbol(input itp_pkg::op_code_t c);
		unique case (c)
			itp_pkg::OP_OPEN: return itp_pkg::CH_OPEN;
			itp_pkg::OP_PLUS: return itp_pkg::CH_PLUS;
			itp_pkg::OP_MINUS: return itp_pkg::CH_MINUS;
			itp_pkg::OP_MUL: return itp_pkg::CH_MUL;
			itp_pkg::OP_DIV: return itp_pkg::CH_DIV;
			default: return 8'h00;
		endcase
	endfunction

	function automatic void add_result(input logic [7:0] sym, input logic has,
			input itp_pkg::status_t st);
		postfix_res_t r;
		r.sym = sym;
		r.has_sym = has;
		r.status = st;
		r.last_of_item = 1'b0;
		r.expr_end = 1'b0;
		char_results_q.push_back(r);
	endfunction

	function automatic void pop_operator();
		add_result(op_symbol(op_stack[op_depth-1]), 1'b1, itp_pkg::ST_OK);
		op_depth--;
	endfunction

	function automatic void push_operator(input itp_pkg::op_code_t c);
		if (op_depth >= DEPTH) begin
			add_result(8'h00, 1'b0, itp_pkg::ST_OVERFLOW);
		end else begin
			op_stack[op_depth] = c;
			op_depth++;
		end
	endfunction

	// Updates the operator stack for one character and leaves its results in char_results_q.
	function automatic void shunt_char(input logic [7:0] sym, input logic fin);
		itp_pkg::op_code_t code;
		logic is_close;
		int n;
		char_results_q.delete();
		code = itp_pkg::OP_NONE;
		is_close = 1'b0;
		unique case (sym)
			itp_pkg::CH_OPEN: code = itp_pkg::OP_OPEN;
			itp_pkg::CH_PLUS: code = itp_pkg::OP_PLUS;
			itp_pkg::CH_MINUS: code = itp_pkg::OP_MINUS;
			itp_pkg::CH_MUL: code = itp_pkg::OP_MUL;
			itp_pkg::CH_DIV: code = itp_pkg::OP_DIV;
			itp_pkg::CH_CLOSE: is_close = 1'b1;
			default: code = itp_pkg::OP_NONE;
		endcase
		if (is_close) begin
			while (op_depth > 0 && op_stack[op_depth-1] != itp_pkg::OP_OPEN)
				pop_operator();
			if (op_depth > 0)
				op_depth--;
			else
				add_result(8'h00, 1'b0, itp_pkg::ST_UNMATCHED);
		end else if (code == itp_pkg::OP_OPEN) begin
			push_operator(code);
		end else if (code != itp_pkg::OP_NONE) begin
			add_result(itp_pkg::CH_SPACE, 1'b1, itp_pkg::ST_OK);
			while (op_depth > 0 && op_rank(op_stack[op_depth-1]) >= op_rank(code))
				pop_operator();
			push_operator(code);
		end else begin
			add_result(sym, 1'b1, itp_pkg::ST_OK);
		end
		if (fin) begin
			while (op_depth > 0)
				pop_operator();
			if (char_results_q.size() == 0)
				add_result(8'h00, 1'b0, itp_pkg::ST_OK);
			n = char_results_q.size();
			char_results_q[n-1].expr_end = 1'b1;
		end
		n = char_results_q.size();
		if (n > 0)
			char_results_q[n-1].last_of_item = 1'b1;
	endfunction

	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 15);
		if (burst)
			return 0;
		if (r < 8)
			return 0;
		if (r < 14)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic is_special(input logic [7:0] sym);
		unique case (sym)
			itp_pkg::CH_OPEN, itp_pkg::CH_CLOSE, itp_pkg::CH_PLUS, itp_pkg::CH_MINUS,
			itp_pkg::CH_MUL, itp_pkg::CH_DIV: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] operand_char();
		logic [7:0] s;
		s = 8'($urandom_range(0, 255));
		while (is_special(s))
			s = 8'($urandom_range(0, 255));
		return s;
	endfunction

	function automatic logic [7:0] operator_char();
		unique case ($urandom_range(0, 3))
			0: return itp_pkg::CH_PLUS;
			1: return itp_pkg::CH_MINUS;
			2: return itp_pkg::CH_MUL;
			default: return itp_pkg::CH_DIV;
		endcase
	endfunction

	task automatic send_item(input logic [7:0] sym, input logic fin, input logic typed,
			input postfix_res_t typed_res);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= sym;
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		shunt_char(sym, fin);
		if (typed)
			expected_postfix_q.push_back(typed_res);
		else
			foreach (char_results_q[i])
				expected_postfix_q.push_back(char_results_q[i]);
		sent_count++;
		gap = sender_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Holds one character back so that the last character of an expression can carry tlast.
	task automatic queue_char(input logic [7:0] sym);
		if (have_held)
			send_item(held_sym, 1'b0, 1'b0, blank_res);
		held_sym = sym;
		have_held = 1'b1;
	endtask

	task automatic close_expression(input logic fin);
		send_item(held_sym, fin, 1'b0, blank_res);
		have_held = 1'b0;
	endtask

	task automatic send_expression();
		int terms;
		int open_cnt;
		int nest;
		int k;
		int j;
		terms = $urandom_range(1, 6);
		open_cnt = 0;
		nest = ($urandom_range(0, 7) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 2) : 0;
		for (j = 0; j < nest; j++) begin
			queue_char(itp_pkg::CH_OPEN);
			open_cnt++;
		end
		for (k = 0; k < terms; k++) begin
			if (k > 0)
				queue_char(operator_char());
			if ($urandom_range(0, 3) == 0) begin
				queue_char(itp_pkg::CH_OPEN);
				open_cnt++;
			end
			for (j = $urandom_range(1, 2); j > 0; j--)
				queue_char(operand_char());
			if (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
				queue_char(itp_pkg::CH_CLOSE);
				open_cnt--;
			end
		end
		if ($urandom_range(0, 2) != 0)
			for (j = 0; j < open_cnt; j++)
				queue_char(itp_pkg::CH_CLOSE);
		if ($urandom_range(0, 9) == 0)
			queue_char(itp_pkg::CH_CLOSE);
		close_expression(1'b1);
	endtask

	task automatic send_noise();
		int n;
		int k;
		n = $urandom_range(1, 8);
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 1) == 0)
				queue_char(8'($urandom_range(0, 255)));
			else if ($urandom_range(0, 5) == 0)
				queue_char(itp_pkg::CH_SPACE);
			else if ($urandom_range(0, 2) == 0)
				queue_char($urandom_range(0, 1) ? itp_pkg::CH_OPEN : itp_pkg::CH_CLOSE);
			else
				queue_char(operator_char());
		end
		close_expression(1'($urandom_range(0, 1)));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_postfix_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string what, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (want_v !== got_v) begin
			mismatch_count++;
			$display("%0t: %s expected %h actual %h", $time, what, want_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_postfix_q.size());
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_postfix_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected transaction expected none actual %h %h %b", $time,
					m_tdata, m_tuser, m_tlast);
			end else begin
				got_want = expected_postfix_q.pop_front();
				check_field("out_symbol", 16'(got_want.sym), 16'(m_tdata[7:0]));
				check_field("last_of_item", 16'(got_want.last_of_item), 16'(m_tdata[8]));
				check_field("tdata padding", 16'h0000,
					16'(m_tdata[itp_pkg::OUT_TDATA_W-1:9]));
				check_field("has_symbol", 16'(got_want.has_sym), 16'(m_tuser[0]));
				check_field("status", 16'(got_want.status), 16'(m_tuser[2:1]));
				check_field("expr_end", 16'(got_want.expr_end), 16'(m_tlast));
			end
		end
	end

	initial begin : receiver
		int n;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rx) begin
				m_tready <= 1'b0;
				for (n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				hold_rx = 1'b0;
			end else if (burst || $urandom_range(0, 3) != 0) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= 1'b0;
				n = ($urandom_range(0, 15) < 12) ? $urandom_range(1, 3) : $urandom_range(10, 40);
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin : sender
		int k;
		int r;
		int target;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		burst = 1'b0;
		hold_rx = 1'b0;
		have_held = 1'b0;
		held_sym = '0;
		op_depth = 0;
		mismatch_count = 0;
		sent_count = 0;
		cycle_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			for (r = 0; r < directed_rows[i].reps; r++)
				send_item(directed_rows[i].sym, directed_rows[i].fin, directed_rows[i].typed,
					directed_rows[i].res);
		wait_drained();

		target = sent_count + RANDOM_ITEMS;
		while (sent_count < target - RANDOM_ITEMS / 2) begin
			burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0)
				send_noise();
			else
				send_expression();
		end

		// The receiver stalls while characters keep coming, so the block backs up.
		burst = 1'b1;
		hold_rx = 1'b1;
		for (k = 0; k < 30; k++)
			queue_char(operand_char());
		close_expression(1'b1);
		burst = 1'b0;
		wait_drained();

		while (sent_count < target) begin
			burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0)
				send_noise();
			else
				send_expression();
		end
		burst = 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
